### design/wrsd_pkg.sv
// ----------------------------------------------------------------------------
// wrsd_pkg
// Shared types and constants for the window range stability detector.
// ----------------------------------------------------------------------------
package wrsd_pkg;

  localparam int SAMPLE_W    = 19;
  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 8;
  localparam logic [SAMPLE_W-1:0] SPAN_RESET = 19'd20;

  // bit positions inside the stream words
  localparam int ROLL_LSB    = 0;
  localparam int UPDATE_BIT  = 19;
  localparam int STABLE_BIT  = 0;
  localparam int ALLOWED_BIT = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_CHECK,
    ST_DONE
  } wrsd_state_t;

  // tags that travel with each window entry read out during a scan
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } wrsd_scan_t;

endpackage

### design/wrsd_window.sv
// ----------------------------------------------------------------------------
// wrsd_window
// Circular sample window: one write port, one registered read port.
// ----------------------------------------------------------------------------
module wrsd_window #(
  parameter int DEPTH = 200,
  parameter int AW    = 8
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [AW-1:0]                 waddr,
  input  logic [wrsd_pkg::SAMPLE_W-1:0] wdata,
  input  logic [AW-1:0]                 raddr,
  output logic [wrsd_pkg::SAMPLE_W-1:0] rdata
);

  logic [wrsd_pkg::SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### design/wrsd_minmax.sv
// ----------------------------------------------------------------------------
// wrsd_minmax
// Running minimum and maximum over the entries streamed out of the window.
// ----------------------------------------------------------------------------
module wrsd_minmax (
  input  logic                          clk,
  input  wrsd_pkg::wrsd_scan_t          scan,
  input  logic [wrsd_pkg::SAMPLE_W-1:0] data,
  output logic [wrsd_pkg::SAMPLE_W-1:0] lo,
  output logic [wrsd_pkg::SAMPLE_W-1:0] hi
);

  always_ff @(posedge clk) begin
    if (scan.vld) begin
      if (scan.first) begin
        lo <= data;
        hi <= data;
      end else begin
        if (data < lo) begin
          lo <= data;
        end
        if (data > hi) begin
          hi <= data;
        end
      end
    end
  end

endmodule

### design/window_range_stability_detector.sv
// ----------------------------------------------------------------------------
// window_range_stability_detector
// Sliding-window min/max span check with a sticky stable flag.
// ----------------------------------------------------------------------------
// Each accepted word writes its sample into a circular window of WINDOW_DEPTH
// entries and returns one result word. While the window is not yet full, or
// once the sticky stable flag is set, a word goes from ST_IDLE straight to
// ST_DONE, which loads its result into the output register. Otherwise the
// window is scanned through its single read port, one entry per cycle into one
// shared min/max compare unit (ST_SCAN, then ST_WAIT for the last read); a span
// subtract-and-compare step (ST_CHECK) follows, then ST_DONE. s_tready is low
// while a word is in progress; a result waiting on m_tready does not block
// acceptance of the next word, though that word's result then waits for the
// output register. The window memory needs no clearing after reset, since it
// is only scanned once every entry has been written.
// ----------------------------------------------------------------------------
module window_range_stability_detector #(
  parameter int WINDOW_DEPTH = 200
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [18:0] roll_sample, [19] sw_update, [23:20] zero
  input  logic [wrsd_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] sensor_stable, [1] control_allowed, [7:2] zero
  output logic [wrsd_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic                           stable_span_we,
  input  logic [wrsd_pkg::SAMPLE_W-1:0]  stable_span_wdata
);

  localparam int AW = $clog2(WINDOW_DEPTH);
  localparam int FW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(WINDOW_DEPTH);
  localparam logic [FW-1:0] FILL_PRE  = FW'(WINDOW_DEPTH - 1);

  wrsd_pkg::wrsd_state_t state, state_next;

  logic                          accept;
  logic [AW-1:0]                 wpos;
  logic [FW-1:0]                 fill_count;
  logic                          stable_flag;
  logic                          upd;
  logic [wrsd_pkg::SAMPLE_W-1:0] stable_span;
  logic [AW-1:0]                 rd_addr;
  wrsd_pkg::wrsd_scan_t          scan_issue, scan_q;
  logic [wrsd_pkg::SAMPLE_W-1:0] rdata;
  logic [wrsd_pkg::SAMPLE_W-1:0] lo, hi;
  logic [wrsd_pkg::SAMPLE_W-1:0] span;
  logic                          fill_full_next;
  logic                          out_free;
  logic                          load_out;
  logic [wrsd_pkg::M_TDATA_W-1:0] out_word;

  assign accept         = s_tvalid & s_tready;
  assign fill_full_next = (fill_count >= FILL_PRE);
  assign out_free       = ~m_tvalid | m_tready;
  assign span           = hi - lo;

  always_comb begin
    scan_issue.vld   = (state == wrsd_pkg::ST_SCAN);
    scan_issue.first = (rd_addr == '0);
    scan_issue.last  = (rd_addr == LAST_ADDR);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wrsd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      wrsd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          // no scan before the window is full or once the flag has stuck
          if (stable_flag || !fill_full_next) begin
            state_next = wrsd_pkg::ST_DONE;
          end else begin
            state_next = wrsd_pkg::ST_SCAN;
          end
        end
      end
      wrsd_pkg::ST_SCAN: begin
        if (scan_issue.last) begin
          state_next = wrsd_pkg::ST_WAIT;
        end
      end
      wrsd_pkg::ST_WAIT: begin
        if (scan_q.last) begin
          state_next = wrsd_pkg::ST_CHECK;
        end
      end
      wrsd_pkg::ST_CHECK: begin
        state_next = wrsd_pkg::ST_DONE;
      end
      wrsd_pkg::ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = wrsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wrsd_pkg::ST_IDLE;
      end
    endcase
  end

  // window bookkeeping, flag and threshold
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos        <= '0;
      fill_count  <= '0;
      stable_flag <= 1'b0;
      stable_span <= wrsd_pkg::SPAN_RESET;
      rd_addr     <= '0;
      scan_q      <= '0;
    end else begin
      if (stable_span_we) begin
        stable_span <= stable_span_wdata;
      end
      if (accept) begin
        wpos <= (wpos == LAST_ADDR) ? '0 : wpos + AW'(1);
        if (fill_count != FILL_FULL) begin
          fill_count <= fill_count + FW'(1);
        end
      end
      if (state == wrsd_pkg::ST_SCAN) begin
        rd_addr <= rd_addr + AW'(1);
      end else begin
        rd_addr <= '0;
      end
      scan_q <= scan_issue;
      if (state == wrsd_pkg::ST_CHECK && span < stable_span) begin
        stable_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      upd <= s_tdata[wrsd_pkg::UPDATE_BIT];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_comb begin
    out_word                        = '0;
    out_word[wrsd_pkg::STABLE_BIT]  = stable_flag;
    out_word[wrsd_pkg::ALLOWED_BIT] = stable_flag & ~upd;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= out_word;
    end
  end

  wrsd_window #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_window (
    .clk   (clk),
    .we    (accept),
    .waddr (wpos),
    .wdata (s_tdata[wrsd_pkg::ROLL_LSB +: wrsd_pkg::SAMPLE_W]),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  wrsd_minmax u_minmax (
    .clk  (clk),
    .scan (scan_q),
    .data (rdata),
    .lo   (lo),
    .hi   (hi)
  );

endmodule

### design/wrsd_checker.sv
// ----------------------------------------------------------------------------
// wrsd_checker
// Port-level checks for the window range stability detector.
// ----------------------------------------------------------------------------
module wrsd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [wrsd_pkg::M_TDATA_W-1:0] m_tdata
);

  logic seen_stable;

  // remembers that a stable result has been delivered since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_stable <= 1'b0;
    end else if (m_tvalid && m_tready && m_tdata[wrsd_pkg::STABLE_BIT]) begin
      seen_stable <= 1'b1;
    end
  end

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && seen_stable) |-> m_tdata[wrsd_pkg::STABLE_BIT])
    else $error("stable flag dropped after it was reported");

  a_allowed_needs_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[wrsd_pkg::ALLOWED_BIT] && !m_tdata[wrsd_pkg::STABLE_BIT]))
    else $error("control allowed without stable flag");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("ready right after accepting a word");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind window_range_stability_detector wrsd_checker u_wrsd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### bench/tb_window_range_stability_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_range_stability_detector
// Streams lean-angle words through the window span detector under random
// source gaps and sink stalls. A local window copy predicts the sticky stable
// flag and the control-allowed bit of every result word. The threshold is
// reprogrammed between phases: zero, span equal to threshold, a wide band, a
// narrow band that settles, and maximum then zero once the flag is stuck.
// ----------------------------------------------------------------------------
module tb_window_range_stability_detector;

  localparam int DEPTH = 200;
  localparam int SW    = wrsd_pkg::SAMPLE_W;
  localparam logic [SW-1:0] ROLL_MAX = 19'h7FFFF;
  localparam logic [SW-1:0] ROLL_FULL_SCALE = 19'd360000;

  typedef struct packed {
    logic          upd;
    logic [SW-1:0] roll;
  } roll_word_t;

  typedef struct packed {
    logic allowed;
    logic stable;
  } verdict_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [wrsd_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [wrsd_pkg::M_TDATA_W-1:0] m_tdata;
  logic                           stable_span_we = 1'b0;
  logic [SW-1:0]                  stable_span_wdata = '0;

  window_range_stability_detector #(
    .WINDOW_DEPTH(DEPTH)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .s_tvalid         (s_tvalid),
    .s_tready         (s_tready),
    .s_tdata          (s_tdata),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .stable_span_we   (stable_span_we),
    .stable_span_wdata(stable_span_wdata)
  );

  always #5 clk = ~clk;

  // local copy of the detector state
  logic [SW-1:0] window_copy [DEPTH];
  int unsigned   wr_slot = 0;
  int unsigned   filled = 0;
  logic          stable_seen = 1'b0;
  logic [SW-1:0] span_limit = wrsd_pkg::SPAN_RESET;

  verdict_t    expected_verdicts[$];
  roll_word_t  pending_words[$];
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned stable_at = 0;
  int unsigned mismatches = 0;

  task automatic absorb_sample(input roll_word_t w);
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    verdict_t      v;
    window_copy[wr_slot] = w.roll;
    wr_slot = (wr_slot == DEPTH - 1) ? 0 : wr_slot + 1;
    if (filled < DEPTH) filled++;
    // span is only tested on a full window and only until the flag sticks
    if (!stable_seen && filled == DEPTH) begin
      lo = window_copy[0];
      hi = window_copy[0];
      for (int i = 1; i < DEPTH; i++) begin
        if (window_copy[i] < lo) lo = window_copy[i];
        if (window_copy[i] > hi) hi = window_copy[i];
      end
      if (hi - lo < span_limit) begin
        stable_seen = 1'b1;
        stable_at = words_sent;
      end
    end
    v.stable = stable_seen;
    v.allowed = stable_seen && !w.upd;
    expected_verdicts.push_back(v);
  endtask

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch at result word %0d: %s, expected %0d, got %0d",
               $time, words_checked, what, want, got);
  endtask

  // source side
  int unsigned                    src_pause;
  logic                           src_calm;
  logic                           src_next;
  roll_word_t                     src_word;
  logic [wrsd_pkg::S_TDATA_W-1:0] src_bus;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_pause = 0;
      src_calm = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        words_sent++;
        absorb_sample(src_word);
        if ($urandom_range(0, 31) == 0) src_calm = !src_calm;
        src_pause = src_calm ? 0 : $urandom_range(0, 8);
      end
      if (!s_tvalid || s_tready) begin
        src_next = 1'b0;
        if (src_pause > 0) begin
          src_pause--;
        end else if (pending_words.size() > 0) begin
          src_word = pending_words.pop_front();
          src_bus = '0;
          src_bus[wrsd_pkg::ROLL_LSB +: SW] = src_word.roll;
          src_bus[wrsd_pkg::UPDATE_BIT] = src_word.upd;
          s_tdata <= src_bus;
          src_next = 1'b1;
        end
        s_tvalid <= src_next;
      end
    end
  end

  // sink side
  int unsigned sink_pause;
  logic        sink_calm;
  logic        sink_drawn;
  logic        sink_next;
  verdict_t    sink_want;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_pause = 0;
      sink_calm = 1'b0;
      sink_drawn = 1'b0;
    end else begin
      sink_next = 1'b0;
      if (m_tvalid && m_tready) begin
        words_checked++;
        sink_drawn = 1'b0;
        if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("result word with nothing expected", 0, 32'(m_tdata));
        end else begin
          sink_want = expected_verdicts.pop_front();
          if (m_tdata[wrsd_pkg::STABLE_BIT] !== sink_want.stable)
            flag_mismatch("sensor_stable", 32'(sink_want.stable),
                          32'(m_tdata[wrsd_pkg::STABLE_BIT]));
          if (m_tdata[wrsd_pkg::ALLOWED_BIT] !== sink_want.allowed)
            flag_mismatch("control_allowed", 32'(sink_want.allowed),
                          32'(m_tdata[wrsd_pkg::ALLOWED_BIT]));
        end
        sink_next = sink_calm || $urandom_range(0, 1);
      end else if (m_tvalid) begin
        // stall a freshly presented word for a randomly drawn pause
        if (!sink_drawn) begin
          sink_pause = sink_calm ? 0 : $urandom_range(0, 8);
          sink_drawn = 1'b1;
        end
        if (sink_pause == 0) sink_next = 1'b1;
        else sink_pause--;
      end else begin
        sink_next = sink_calm || $urandom_range(0, 1);
      end
      m_tready <= sink_next;
    end
  end

  task automatic queue_word(input logic [SW-1:0] roll, input logic upd);
    roll_word_t w;
    w.roll = roll;
    w.upd = upd;
    pending_words.push_back(w);
  endtask

  // samples in base..base+width, with noise_pct percent of full-range words
  task automatic queue_band(input int unsigned count, input int unsigned base,
                            input int unsigned width, input int unsigned noise_pct);
    logic [SW-1:0] roll;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < noise_pct) roll = SW'($urandom_range(0, ROLL_MAX));
      else roll = SW'(base + $urandom_range(0, width));
      queue_word(roll, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || s_tvalid || expected_verdicts.size() != 0);
  endtask

  task automatic write_span(input logic [SW-1:0] value);
    wait_idle();
    @(posedge clk);
    stable_span_we <= 1'b1;
    stable_span_wdata <= value;
    @(posedge clk);
    stable_span_we <= 1'b0;
    span_limit = value;
    @(negedge clk);
  endtask

  initial begin
    int unsigned hold_level;
    int unsigned band_base;
    int unsigned band_span;
    int unsigned narrow_base;
    int unsigned narrow_span;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // field extremes while the window is still filling
    queue_word('0, 1'b0);
    queue_word(ROLL_FULL_SCALE, 1'b1);
    queue_word(ROLL_MAX, 1'b0);
    queue_word(ROLL_MAX, 1'b1);
    queue_word(19'd1, 1'b1);
    queue_word(ROLL_FULL_SCALE + 19'd1, 1'b0);
    queue_word(19'h40000, 1'b1);
    queue_word(19'h3FFFF, 1'b0);
    queue_word(19'h55555, 1'b1);
    queue_word(19'h2AAAA, 1'b0);
    // narrow span, but no test until the window is full
    for (int i = 0; i < 10; i++) queue_word(19'd500, 1'(i % 2));

    // zero threshold: even a flat window never counts as stable
    write_span('0);
    hold_level = $urandom_range(50000, 100000);
    queue_band(230, hold_level, 0, 0);

    // span exactly at the threshold is not below it
    write_span(19'd1);
    for (int i = 0; i < 200; i++)
      queue_word(SW'(hold_level + ((i % 2 == 0) ? 1 : 0)), 1'($urandom_range(0, 1)));

    // wide band, spread just beyond the threshold
    band_span = $urandom_range(1000, 50000);
    band_base = $urandom_range(200000, 300000);
    write_span(SW'(band_span));
    queue_band(200, band_base, band_span + band_span / 8, 10);

    // narrow band settles once the outlier has left the window
    narrow_span = $urandom_range(100, 2000);
    narrow_base = $urandom_range(0, ROLL_MAX - 2000);
    write_span(SW'(narrow_span));
    queue_band(40, narrow_base, narrow_span - 1, 0);
    queue_word((narrow_base < 262144) ? ROLL_MAX : '0, 1'($urandom_range(0, 1)));
    queue_band(259, narrow_base, narrow_span - 1, 0);

    // flag is sticky whatever the threshold does now
    write_span(ROLL_MAX);
    queue_band(50, 0, 0, 100);
    write_span('0);
    queue_band(50, 0, 0, 100);

    wait_idle();
    repeat (2 * DEPTH + 16) @(negedge clk);
    if (expected_verdicts.size() != 0)
      flag_mismatch("result words never delivered", 0, 32'(expected_verdicts.size()));
    $display("%0d sample words sent, %0d result words checked, thresholds 0, 1, %0d, %0d, max",
             words_sent, words_checked, band_span, narrow_span);
    if (stable_seen) $display("window went stable at sample word %0d", stable_at);
    else $display("window never went stable");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #15_000_000;
    $display("run timed out with %0d result words still expected", expected_verdicts.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
